// ===== rtl/rdmpm_pkg.sv =====
package rdmpm_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned RunW    = 9;
  localparam int unsigned StampW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [CfgIdxW-1:0] RegRedLevel   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinRun     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPowerScale = 2'd2;

  localparam logic [LevelW-1:0] RedLevelRst   = 12'd2048;
  localparam logic [CountW-1:0] MinRunRst     = 8'd3;
  localparam logic [ScaleW-1:0] PowerScaleRst = 24'd480000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_PWR_GO,
    ST_PWR_WAIT,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic judge;
    logic store_pwr;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_pwr;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/rdmpm_div.sv =====
module rdmpm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rdmpm_pkg::ScaleW-1:0] num_i,
  input  logic [rdmpm_pkg::StampW-1:0] den_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [rdmpm_pkg::ScaleW-1:0] quo_o
);
  import rdmpm_pkg::*;

  localparam int unsigned CntW = $clog2(ScaleW);

  logic [StampW-1:0] rem_q, rem_d;
  logic [ScaleW-1:0] quo_q, quo_d;
  logic [StampW-1:0] den_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StampW:0]   shifted;
  logic [StampW:0]   trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[ScaleW-1]};
    trial   = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[StampW]) begin
        rem_d = shifted[StampW-1:0];
        quo_d = {quo_q[ScaleW-2:0], 1'b0};
      end else begin
        rem_d = trial[StampW-1:0];
        quo_d = {quo_q[ScaleW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ScaleW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/rdmpm_dp.sv =====
module rdmpm_dp #(
  parameter int unsigned AVG_TAPS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rdmpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rdmpm_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [rdmpm_pkg::SampleW-1:0]  sample_i,
  input  rdmpm_pkg::ctrl_cmd_t           cmd_i,
  output rdmpm_pkg::dp_status_t          status_o,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [rdmpm_pkg::OutDataW-1:0] m_tdata_o
);
  import rdmpm_pkg::*;

  localparam int unsigned SumW = SampleW + $clog2(AVG_TAPS);
  // floor(sum / AVG_TAPS) as (sum * ceil(2^DivShift / AVG_TAPS)) >> DivShift
  localparam int unsigned DivShift = SumW + $clog2(AVG_TAPS);
  localparam int unsigned RecipW   = SumW + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << DivShift) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

  logic [LevelW-1:0]  red_level_q;
  logic [CountW-1:0]  min_run_q;
  logic [ScaleW-1:0]  scale_q;

  logic [SampleW-1:0] win_q [AVG_TAPS];
  logic [SumW-1:0]    sum_q;
  logic [RunW-1:0]    run_q;
  logic [StampW-1:0]  count_q;
  logic [StampW-1:0]  prev_q;
  logic [StampW-1:0]  latest_q;

  logic [SampleW-1:0] avg_q;
  logic               above_q;
  logic               mark_q;
  logic               pvalid_q;
  logic [ScaleW-1:0]  watts_q;

  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [ScaleW-1:0]  div_num;
  logic [StampW-1:0]  div_den;
  logic [ScaleW-1:0]  div_quo;

  logic [SumW+RecipW-1:0] avg_prod;
  logic [SampleW-1:0] avg_c;
  logic               above_c;
  logic [RunW-1:0]    run_inc;
  logic               mark_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_level_q <= RedLevelRst;
      min_run_q   <= MinRunRst;
      scale_q     <= PowerScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRedLevel:   red_level_q <= cfg_data_i[LevelW-1:0];
        RegMinRun:     min_run_q   <= cfg_data_i[CountW-1:0];
        RegPowerScale: scale_q     <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // window shift line and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AVG_TAPS; k++) begin
        win_q[k] <= '0;
      end
      sum_q <= '0;
    end else if (cmd_i.load) begin
      for (int k = 0; k < AVG_TAPS - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[AVG_TAPS-1] <= sample_i;
      sum_q <= sum_q - SumW'(win_q[0]) + SumW'(sample_i);
    end
  end

  assign div_start = cmd_i.div_start;
  assign div_num   = scale_q;
  assign div_den   = latest_q - prev_q;

  rdmpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign avg_prod = {{RecipW{1'b0}}, sum_q} * {{SumW{1'b0}}, Recip};
  assign avg_c    = avg_prod[DivShift +: SampleW];
  assign above_c  = avg_c > red_level_q;
  assign run_inc  = (run_q <= RunW'(min_run_q)) ? run_q + 1'b1 : run_q;
  assign mark_c   = above_c && (run_inc == RunW'(min_run_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= '0;
      count_q  <= '0;
      prev_q   <= '0;
      latest_q <= '0;
    end else if (cmd_i.judge) begin
      run_q   <= above_c ? run_inc : '0;
      count_q <= count_q + 1'b1;
      if (mark_c) begin
        prev_q   <= latest_q;
        latest_q <= count_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.judge) begin
      avg_q    <= avg_c;
      above_q  <= above_c;
      mark_q   <= mark_c;
      pvalid_q <= mark_c && (latest_q != '0);
      watts_q  <= '0;
    end else if (cmd_i.store_pwr) begin
      watts_q <= div_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= {1'b0, watts_q, pvalid_q, mark_q, above_q, avg_q};
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.need_pwr = mark_c && (latest_q != '0);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_pvalid_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_data_q[14] || out_data_q[13]))
    else $error("power reported without a mark");
  a_mark_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_data_q[13] || out_data_q[12]))
    else $error("mark reported below level");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten");
`endif

endmodule

// ===== rtl/rdmpm_ctrl.sv =====
module rdmpm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  rdmpm_pkg::dp_status_t status_i,
  output rdmpm_pkg::ctrl_cmd_t  cmd_o
);
  import rdmpm_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_tvalid_i) state_d = ST_JUDGE;
      ST_JUDGE:    state_d = status_i.need_pwr ? ST_PWR_GO : ST_PUSH;
      ST_PWR_GO:   state_d = ST_PWR_WAIT;
      ST_PWR_WAIT: if (status_i.div_done) state_d = ST_PUSH;
      ST_PUSH:     if (status_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_JUDGE:    cmd_o.judge = 1'b1;
      ST_PWR_GO:   cmd_o.div_start = 1'b1;
      ST_PWR_WAIT: cmd_o.store_pwr = status_i.div_done;
      ST_PUSH:     cmd_o.push = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rotating_disc_mark_power_meter.sv =====
// Channel     Dir  Payload
// s_axis      in   tdata[11:0] sample
// m_axis      out  tdata[11:0] average, [12] above_level, [13] mark_start,
//                  [14] power_valid, [38:15] power_watts
// cfg         in   write enable, index 0..2, 24-bit data
//
// Steps per item: accept, judge, push, and a power division before the push
// when a power value is computed, on a bit-serial divider at one quotient
// bit a cycle; the average is a reciprocal multiply by a constant.
// Reset is asynchronous, active low, and restores the register defaults.
// A finished item waits in the output register; the next sample is taken
// meanwhile and only its final write waits for the output to drain.
module rotating_disc_mark_power_meter #(
  parameter int unsigned AVG_TAPS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rdmpm_pkg::InDataW-1:0]  s_axis_tdata_i,  // sample
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // average, above_level, mark_start, power_valid, power_watts, pad
  output logic [rdmpm_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [rdmpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rdmpm_pkg::CfgW-1:0]     cfg_data_i
);
  import rdmpm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rdmpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdmpm_dp #(
    .AVG_TAPS (AVG_TAPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata_i[SampleW-1:0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== dv/rotating_disc_mark_power_meter_tb.sv =====
`timescale 1ns / 100ps

module rotating_disc_mark_power_meter_tb;
  import rdmpm_pkg::*;

  localparam int unsigned Taps = 8;
  localparam int unsigned Limit = 1_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned Phases = 6;
  localparam int unsigned PhaseItems = 125;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [ScaleW-1:0]  watts;
    logic               pvalid;
    logic               mark;
    logic               above;
    logic [SampleW-1:0] avg;
  } reading_t;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
    logic [SampleW-1:0] smp;
    bit                 typed;
    reading_t           want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  // meter model state
  logic [LevelW-1:0]  red_level;
  logic [CountW-1:0]  min_run;
  logic [ScaleW-1:0]  power_scale;
  logic [SampleW-1:0] taps_q [Taps];
  logic [RunW-1:0]    run_len;
  logic [StampW-1:0]  n_samples;
  logic [StampW-1:0]  prev_stamp;
  logic [StampW-1:0]  last_stamp;

  reading_t    readings_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_no = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // directed items; typed expectations only where obvious
  row_t dir_tab [37] = '{
    '{ROW_CFG,  RegRedLevel,   24'hFFF000, 12'd0,    1'b0, '0},
    '{ROW_CFG,  RegMinRun,     24'hABCD01, 12'd0,    1'b0, '0},
    // mark at sample count zero, no power
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b1,
      '{24'd0, 1'b0, 1'b1, 1'b1, 12'd511}},
    // run saturated, no second mark
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b1,
      '{24'd0, 1'b0, 1'b0, 1'b1, 12'd1023}},
    '{ROW_CFG,  RegRedLevel,   24'd4095,   12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd256,    12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd4095,   12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd256,    12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  RegPowerScale, 24'd0,      12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd4095,   12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd256,    12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  RegPowerScale, 24'hFFFFFF, 12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd4095,   12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd256,    12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_CFG,  RegUnused,     24'hFFFFFF, 12'd0,    1'b0, '0},
    // zero minimum run never marks
    '{ROW_CFG,  RegMinRun,     24'd0,      12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    // full-scale average
    '{ROW_CFG,  RegMinRun,     24'd255,    12'd0,    1'b0, '0},
    '{ROW_CFG,  RegRedLevel,   24'd4094,   12'd0,    1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0},
    '{ROW_ITEM, RegRedLevel,   24'd0,      12'd4095, 1'b0, '0}
  };

  rotating_disc_mark_power_meter #(
    .AVG_TAPS(Taps)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void meter_reset();
    red_level   = RedLevelRst;
    min_run     = MinRunRst;
    power_scale = PowerScaleRst;
    foreach (taps_q[k]) taps_q[k] = '0;
    run_len    = '0;
    n_samples  = '0;
    prev_stamp = '0;
    last_stamp = '0;
  endfunction

  function automatic reading_t meter_step(logic [SampleW-1:0] smp);
    reading_t r;
    logic [14:0] sum;
    logic [StampW-1:0] span;
    logic [StampW-1:0] quot;
    r = '0;
    sum = '0;
    for (int k = 0; k < Taps - 1; k++) begin
      taps_q[k] = taps_q[k+1];
      sum = sum + taps_q[k];
    end
    taps_q[Taps-1] = smp;
    sum = sum + smp;
    r.avg = SampleW'(sum / Taps);
    r.above = (r.avg > red_level);
    if (r.above) begin
      if (run_len <= {1'b0, min_run}) run_len = run_len + 1'b1;
      if (run_len == {1'b0, min_run}) begin
        r.mark = 1'b1;
        prev_stamp = last_stamp;
        last_stamp = n_samples;
        if (prev_stamp != '0) begin
          span = last_stamp - prev_stamp;
          quot = (span == '0) ? 32'hFFFFFF : {8'd0, power_scale} / span;
          r.pvalid = 1'b1;
          r.watts = quot[ScaleW-1:0];
        end
      end
    end else begin
      run_len = '0;
    end
    n_samples = n_samples + 1'b1;
    return r;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      RegRedLevel:   red_level = val[LevelW-1:0];
      RegMinRun:     min_run = val[CountW-1:0];
      RegPowerScale: power_scale = val[ScaleW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [SampleW-1:0] smp, bit typed, reading_t want);
    reading_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW-SampleW){1'b0}}, smp};
    do @(posedge clk_i); while (!s_tready);
    r = meter_step(smp);
    readings_due.push_back(typed ? want : r);
  endtask

  // output side: random stall plus one long hold-off
  always @(posedge clk_i) begin
    if (!hold_done && phase_no == 1) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[$bits(reading_t)-1:0];
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", got);
      end else begin
        want = readings_due.pop_front();
        if (got.avg !== want.avg || got.above !== want.above || got.mark !== want.mark ||
            got.pvalid !== want.pvalid || got.watts !== want.watts) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: avg %0d/%0d above %b/%b mark %b/%b pvalid %b/%b watts %0d/%0d",
                     want.avg, got.avg, want.above, got.above, want.mark, got.mark,
                     want.pvalid, got.pvalid, want.watts, got.watts);
        end
      end
    end
  end

  initial begin
    logic [SampleW-1:0] smp;
    int unsigned hi_left;
    int unsigned lo_left;
    meter_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 1; p <= Phases; p++) begin
      write_reg(RegRedLevel, CfgW'($urandom_range(3200, 900)));
      write_reg(RegMinRun, CfgW'($urandom_range(6, 1)));
      write_reg(RegPowerScale, CfgW'(($urandom_range(3) == 0) ? $urandom_range(4000, 1)
                                                              : $urandom_range(24'hFFFFFF, 1)));
      phase_no = p;
      case (p % 4)
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      hi_left = 0;
      lo_left = 0;
      // disc-like square wave with noise
      for (int n = 0; n < PhaseItems; n++) begin
        if (hi_left == 0 && lo_left == 0) begin
          hi_left = $urandom_range(14, 3);
          lo_left = $urandom_range(20, 3);
        end
        if ($urandom_range(9) == 0) begin
          smp = SampleW'($urandom_range(4095));
        end else if (hi_left != 0) begin
          smp = SampleW'($urandom_range(4095, red_level));
          hi_left--;
        end else begin
          smp = SampleW'($urandom_range(red_level, 0));
          lo_left--;
        end
        send_sample(smp, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
